[hw/rtl/rllt_pkg.sv]
package rllt_pkg;

	// Default sizing of the run table
	localparam int MAX_RUNS_DEF  = 256;
	localparam int LINE_BITS_DEF = 16;

	// Fixed field widths of the channels
	localparam int LINE_IN_W = 16;
	localparam int OFFSET_W  = 16;
	localparam int FOUND_W   = 16;
	localparam int STATUS_W  = 2;

	// Run length counter
	localparam int                LEN_W   = 16;
	localparam logic [LEN_W-1:0]  LEN_MAX = {LEN_W{1'b1}};

	typedef enum logic {
		REQ_APPEND = 1'b0,
		REQ_QUERY  = 1'b1
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_APPEND,
		ST_WALK,
		ST_REPLY
	} state_t;

endpackage

[hw/rtl/rllt_req_if.sv]
interface rllt_req_if;
	logic                           valid;
	logic                           ready;
	logic                           req_type;
	logic [rllt_pkg::LINE_IN_W-1:0] line_number;
	logic [rllt_pkg::OFFSET_W-1:0]  byte_offset;

	modport source (output valid, req_type, line_number, byte_offset, input ready);
	modport sink   (input valid, req_type, line_number, byte_offset, output ready);
endinterface

[hw/rtl/rllt_rsp_if.sv]
interface rllt_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [rllt_pkg::STATUS_W-1:0] status;
	logic [rllt_pkg::FOUND_W-1:0]  found_line;

	modport source (output valid, status, found_line, input ready);
	modport sink   (input valid, status, found_line, output ready);
endinterface

[hw/rtl/rllt_ram.sv]
module rllt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry, register the read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/run_length_line_table_core.sv]
// Append: accepted in IDLE, committed in APPEND once the output register is free; the next
//   item is accepted only after that result has been loaded into the output register.
// Query: walks the runs through the table RAM, one run per cycle on its single read port;
//   the walk stops at the run that holds the offset, or after the last run with NOT_FOUND.
//   An empty table answers NOT_FOUND without a walk; no request is taken until the reply is loaded.
// Reset (arst_n low, asynchronous) empties the table and the result register at once.
module run_length_line_table_core #(
	parameter int MAX_RUNS  = rllt_pkg::MAX_RUNS_DEF,
	parameter int LINE_BITS = rllt_pkg::LINE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	rllt_req_if.sink   req,
	rllt_rsp_if.source rsp
);

	localparam int IDX_W = $clog2(MAX_RUNS);
	localparam int TOT_W = $clog2(MAX_RUNS + 1);
	localparam int LEN_W = rllt_pkg::LEN_W;
	localparam int MEM_W = LINE_BITS + LEN_W;
	localparam int OFF_W = rllt_pkg::OFFSET_W;

	rllt_pkg::state_t  state_q, state_d;

	// Request hold registers
	logic [LINE_BITS-1:0] line_q;
	logic [OFF_W-1:0]     offset_q;

	// Table bookkeeping: run count and a copy of the last run
	logic [TOT_W-1:0]     total_q;
	logic [LINE_BITS-1:0] last_line_q;
	logic [LEN_W-1:0]     last_len_q;

	// Walk registers
	logic [IDX_W-1:0]     idx_q;
	logic [OFF_W-1:0]     acc_q;

	// Pending query result and the output register
	rllt_pkg::status_t              res_status_q, res_status_d;
	logic [rllt_pkg::FOUND_W-1:0]   res_line_q, res_line_d;
	logic                           out_valid_q;
	rllt_pkg::status_t              out_status_q, out_status_d;
	logic [rllt_pkg::FOUND_W-1:0]   out_line_q, out_line_d;

	// Control strobes
	logic in_fire, out_free, load_req, walk_start, walk_step, res_load, out_load, app_commit;

	// Table RAM ports
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	logic [MEM_W-1:0] ram_wdata, ram_rdata;

	logic [LINE_BITS-1:0] rd_line;
	logic [LEN_W-1:0]     rd_len;
	logic [31:0]          rd_line_ext, line_in_ext;
	logic [OFF_W:0]       walk_sum;
	logic                 walk_hit, walk_last;
	logic [TOT_W-1:0]     total_m1;
	logic [IDX_W-1:0]     last_idx;
	logic                 same_line, has_room;
	logic [LEN_W-1:0]     new_len;

	rllt_ram #(
		.WIDTH (MEM_W),
		.DEPTH (MAX_RUNS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Handshake
	assign req.ready = (state_q == rllt_pkg::ST_IDLE);
	assign in_fire   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.found_line = out_line_q;

	// Walk datapath: add the run just read, compare against the offset
	assign rd_line     = ram_rdata[MEM_W-1:LEN_W];
	assign rd_len      = ram_rdata[LEN_W-1:0];
	assign rd_line_ext = 32'(rd_line);
	assign walk_sum    = {1'b0, acc_q} + {1'b0, rd_len};
	assign walk_hit    = {1'b0, offset_q} < walk_sum;
	assign total_m1    = total_q - TOT_W'(1);
	assign last_idx    = total_m1[IDX_W-1:0];
	assign walk_last   = (idx_q == last_idx);
	assign ram_raddr   = (state_q == rllt_pkg::ST_WALK) ? idx_q + IDX_W'(1) : '0;

	// Append datapath: extend the last run or open a new one
	assign line_in_ext = 32'(req.line_number);
	assign same_line   = (total_q != '0) && (last_line_q == line_q);
	assign has_room    = total_q < TOT_W'(MAX_RUNS);
	assign new_len     = !same_line ? LEN_W'(1) :
		(last_len_q == rllt_pkg::LEN_MAX) ? last_len_q : last_len_q + LEN_W'(1);
	assign ram_we      = app_commit && (same_line || has_room);
	assign ram_waddr   = same_line ? last_idx : total_q[IDX_W-1:0];
	assign ram_wdata   = {line_q, new_len};

	// Next state and strobes
	always_comb begin
		state_d      = state_q;
		load_req     = 1'b0;
		walk_start   = 1'b0;
		walk_step    = 1'b0;
		res_load     = 1'b0;
		res_status_d = rllt_pkg::STATUS_OK;
		res_line_d   = '0;
		out_load     = 1'b0;
		out_status_d = res_status_q;
		out_line_d   = res_line_q;
		app_commit   = 1'b0;
		case (state_q)
			rllt_pkg::ST_IDLE: begin
				if (in_fire) begin
					load_req = 1'b1;
					if (req.req_type == rllt_pkg::REQ_APPEND) begin
						state_d = rllt_pkg::ST_APPEND;
					end else if (total_q == '0) begin
						res_load     = 1'b1;
						res_status_d = rllt_pkg::STATUS_NOT_FOUND;
						state_d      = rllt_pkg::ST_REPLY;
					end else begin
						walk_start = 1'b1;
						state_d    = rllt_pkg::ST_WALK;
					end
				end
			end
			rllt_pkg::ST_APPEND: begin
				if (out_free) begin
					app_commit   = 1'b1;
					out_load     = 1'b1;
					out_status_d = (same_line || has_room) ? rllt_pkg::STATUS_OK
						: rllt_pkg::STATUS_FULL;
					out_line_d   = '0;
					state_d      = rllt_pkg::ST_IDLE;
				end
			end
			rllt_pkg::ST_WALK: begin
				if (walk_hit) begin
					res_load     = 1'b1;
					res_line_d   = rd_line_ext[rllt_pkg::FOUND_W-1:0];
					state_d      = rllt_pkg::ST_REPLY;
				end else if (walk_last) begin
					res_load     = 1'b1;
					res_status_d = rllt_pkg::STATUS_NOT_FOUND;
					state_d      = rllt_pkg::ST_REPLY;
				end else begin
					walk_step = 1'b1;
				end
			end
			rllt_pkg::ST_REPLY: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = rllt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rllt_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rllt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Run count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ram_we && !same_line) begin
				total_q <= total_q + TOT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load_req) begin
			line_q   <= line_in_ext[LINE_BITS-1:0];
			offset_q <= req.byte_offset;
		end
		if (ram_we) begin
			last_line_q <= line_q;
			last_len_q  <= new_len;
		end
		if (walk_start) begin
			idx_q <= '0;
			acc_q <= '0;
		end else if (walk_step) begin
			idx_q <= idx_q + IDX_W'(1);
			acc_q <= walk_sum[OFF_W-1:0];
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_line_q   <= res_line_d;
		end
		if (out_load) begin
			out_status_q <= out_status_d;
			out_line_q   <= out_line_d;
		end
	end

	// The walk index never passes the last run in use
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rllt_pkg::ST_WALK) |-> (TOT_W'(idx_q) < total_q))
		else $error("walk index beyond run count");

	// The run count never exceeds the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TOT_W'(MAX_RUNS))
		else $error("run count overflow");

	// The table is written only when an append commits
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == rllt_pkg::ST_APPEND && out_free))
		else $error("table write outside append commit");

	// A stalled result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rsp.ready) |-> !out_load)
		else $error("result register overwritten while stalled");

endmodule
